/* src/alr_pkg.sv */
// Shared types and constants for the antialiased line rasterizer.
// No dependencies; every other file in src imports this package.
package alr_pkg;

    localparam int COORD_W   = 12;
    localparam int COLOR_W   = 8;
    localparam int WEIGHT_W  = 6;
    localparam int FRAC_W    = 16;
    localparam int ACC_W     = COORD_W + FRAC_W;
    localparam int STEPS_W   = COORD_W + 1;
    localparam int DCNT_W    = $clog2(FRAC_W + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_RUN_H = 3'd1;
    localparam logic [2:0] MODE_RUN_V = 3'd2;
    localparam logic [2:0] MODE_RUN_D = 3'd3;
    localparam logic [2:0] MODE_AA_Y  = 3'd4;
    localparam logic [2:0] MODE_AA_X  = 3'd5;
    localparam logic [2:0] MODE_FINAL = 3'd6;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] color_index;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [COLOR_W-1:0]  pixel_color;
        logic [WEIGHT_W-1:0] weight;
        logic                opaque;
        logic                last;
    } t_out_item;

    // Decoded command as it travels from front to back.
    typedef struct packed {
        logic               is_start;
        logic [2:0]         mode;
        logic               step_left;
        logic [COORD_W-1:0] sx;      // first dot column
        logic [COORD_W-1:0] sy;      // first dot row
        logic [COORD_W-1:0] cx;      // initial walking column
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COORD_W-1:0] num;     // minor delta, divider numerator
        logic [COORD_W-1:0] den;     // major delta, divider denominator
        logic [STEPS_W-1:0] steps;
        logic [COLOR_W-1:0] color;
    } t_cmd;

endpackage

/* src/alr_front.sv */
// Front end: accepts input items and classifies each start command.
// Depends on alr_pkg.
module alr_front (
    input  alr_pkg::t_in_item i_item,
    input  logic              i_valid,
    output logic              o_ready,
    output alr_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready
);
    import alr_pkg::*;

    logic               swap;
    logic [COORD_W-1:0] sx, sy, ex, ey, dx, dy;
    logic               left;
    logic [2:0]         mode;
    logic [STEPS_W-1:0] steps;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;

    always_comb begin
        // order endpoints so that the first has the smaller row
        swap = i_item.start_y > i_item.end_y;
        sx   = swap ? i_item.end_x   : i_item.start_x;
        sy   = swap ? i_item.end_y   : i_item.start_y;
        ex   = swap ? i_item.start_x : i_item.end_x;
        ey   = swap ? i_item.start_y : i_item.end_y;
        left = ex < sx;
        dx   = left ? sx - ex : ex - sx;
        dy   = ey - sy;

        if (dy == '0) begin
            mode  = MODE_RUN_H;
            steps = {1'b0, dx} + STEPS_W'(1);
        end else if (dx == '0) begin
            mode  = MODE_RUN_V;
            steps = {1'b0, dy};
        end else if (dx == dy) begin
            mode  = MODE_RUN_D;
            steps = {1'b0, dy};
        end else if (dy > dx) begin
            mode  = MODE_AA_Y;
            steps = {1'b0, dy} - STEPS_W'(1);
        end else begin
            mode  = MODE_AA_X;
            steps = {1'b0, dx} - STEPS_W'(1);
        end

        o_cmd.is_start  = i_item.command == CMD_START;
        o_cmd.mode      = mode;
        o_cmd.step_left = left;
        o_cmd.sx        = sx;
        o_cmd.sy        = sy;
        o_cmd.cx        = (mode == MODE_RUN_H && left) ? ex : sx;
        o_cmd.ex        = ex;
        o_cmd.ey        = ey;
        o_cmd.num       = (mode == MODE_AA_Y) ? dx : dy;
        o_cmd.den       = (mode == MODE_AA_Y) ? dy : dx;
        o_cmd.steps     = steps;
        o_cmd.color     = i_item.color_index;
    end

endmodule

/* src/alr_queue.sv */
// Short command queue between the front and the back end.
// Depends on alr_pkg.
module alr_queue #(
    parameter int DEPTH = alr_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  alr_pkg::t_cmd i_wr_data,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    output alr_pkg::t_cmd o_rd_data,
    output logic          o_rd_valid,
    input  logic          i_rd_ready
);
    import alr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en, rd_en;

    assign o_wr_ready = r_count != CNT_W'(DEPTH);
    assign o_rd_valid = r_count != '0;
    assign o_rd_data  = r_mem[r_rptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

/* src/alr_back.sv */
// Back end: line state, slope divider and pixel write generation.
// Depends on alr_pkg.
module alr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  alr_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    output alr_pkg::t_out_item o_item,
    output logic               o_valid,
    input  logic               i_ready
);
    import alr_pkg::*;

    localparam logic [1:0] ST_READY  = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_SECOND = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [2:0]         r_mode, n_mode;
    logic [COORD_W-1:0] r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [COORD_W-1:0] r_fin_x, n_fin_x, r_fin_y, n_fin_y;
    logic               r_left, n_left;
    logic [STEPS_W-1:0] r_steps, n_steps;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [FRAC_W-1:0]  r_estep, n_estep;
    logic [COLOR_W-1:0] r_color, n_color;
    logic [DCNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic [COORD_W-1:0] r_rem, n_rem, r_den, n_den;
    t_out_item          r_out, n_out, r_second, n_second;
    logic               r_out_valid, n_out_valid;

    logic                out_free, pop;
    logic [COORD_W:0]    shifted;
    logic                qbit;
    logic [ACC_W-1:0]    acc_next;
    logic [WEIGHT_W-1:0] w;
    logic [COORD_W-1:0]  ioff, a, nxt_x, nxt_y;
    logic                lst;

    assign out_free    = !r_out_valid || i_ready;
    assign pop         = (r_state == ST_READY) && i_cmd_valid && out_free;
    assign o_cmd_ready = pop;
    assign o_item      = r_out;
    assign o_valid     = r_out_valid;

    always_comb begin
        // one quotient bit per cycle
        shifted  = {r_rem, 1'b0};
        qbit     = shifted >= {1'b0, r_den};
        acc_next = r_acc + ACC_W'(r_estep);
        w        = acc_next[FRAC_W-1 -: WEIGHT_W];
        ioff     = acc_next[ACC_W-1 -: COORD_W];
        nxt_x    = r_left ? r_cur_x - COORD_W'(1) : r_cur_x + COORD_W'(1);
        nxt_y    = r_cur_y + COORD_W'(1);
        a        = '0;
        lst      = r_steps <= STEPS_W'(1);

        n_state     = r_state;
        n_mode      = r_mode;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_fin_x     = r_fin_x;
        n_fin_y     = r_fin_y;
        n_left      = r_left;
        n_steps     = r_steps;
        n_acc       = r_acc;
        n_estep     = r_estep;
        n_color     = r_color;
        n_div_cnt   = r_div_cnt;
        n_rem       = r_rem;
        n_den       = r_den;
        n_out       = r_out;
        n_second    = r_second;
        n_out_valid = r_out_valid && !i_ready;

        case (r_state)
            ST_READY: begin
                if (pop && i_cmd.is_start) begin
                    n_out       = '{pixel_x: i_cmd.sx, pixel_y: i_cmd.sy,
                                    pixel_color: i_cmd.color, weight: '0,
                                    opaque: 1'b0, last: 1'b0};
                    n_out_valid = 1'b1;
                    n_color     = i_cmd.color;
                    n_mode      = i_cmd.mode;
                    n_cur_x     = i_cmd.cx;
                    n_cur_y     = i_cmd.sy;
                    n_fin_x     = i_cmd.ex;
                    n_fin_y     = i_cmd.ey;
                    n_left      = i_cmd.step_left;
                    n_steps     = i_cmd.steps;
                    n_acc       = '0;
                    n_estep     = '0;
                    if (i_cmd.mode == MODE_AA_Y || i_cmd.mode == MODE_AA_X) begin
                        n_rem     = i_cmd.num;
                        n_den     = i_cmd.den;
                        n_div_cnt = DCNT_W'(FRAC_W);
                        n_state   = ST_DIV;
                    end
                end else if (pop) begin
                    case (r_mode)
                        MODE_RUN_H, MODE_RUN_V, MODE_RUN_D: begin
                            n_out       = '{pixel_x: r_cur_x, pixel_y: r_cur_y,
                                            pixel_color: r_color, weight: '0,
                                            opaque: 1'b1, last: lst};
                            n_out_valid = 1'b1;
                            if (r_mode == MODE_RUN_H) begin
                                n_cur_x = r_cur_x + COORD_W'(1);
                            end else begin
                                n_cur_y = nxt_y;
                                if (r_mode == MODE_RUN_D) begin
                                    n_cur_x = nxt_x;
                                end
                            end
                            n_steps = lst ? '0 : r_steps - STEPS_W'(1);
                            if (lst) begin
                                n_mode = MODE_IDLE;
                            end
                        end
                        MODE_AA_Y: begin
                            a        = r_left ? r_cur_x - ioff : r_cur_x + ioff;
                            n_acc    = acc_next;
                            n_cur_y  = nxt_y;
                            n_out    = '{pixel_x: a, pixel_y: nxt_y,
                                         pixel_color: r_color, weight: w,
                                         opaque: 1'b0, last: 1'b0};
                            n_second = '{pixel_x: r_left ? a - COORD_W'(1)
                                                          : a + COORD_W'(1),
                                         pixel_y: nxt_y, pixel_color: r_color,
                                         weight: ~w, opaque: 1'b0, last: 1'b0};
                            n_out_valid = 1'b1;
                            n_state     = ST_SECOND;
                            n_steps     = lst ? '0 : r_steps - STEPS_W'(1);
                            if (lst) begin
                                n_mode = MODE_FINAL;
                            end
                        end
                        MODE_AA_X: begin
                            a        = r_cur_y + ioff;
                            n_acc    = acc_next;
                            n_cur_x  = nxt_x;
                            n_out    = '{pixel_x: nxt_x, pixel_y: a,
                                         pixel_color: r_color, weight: w,
                                         opaque: 1'b0, last: 1'b0};
                            n_second = '{pixel_x: nxt_x, pixel_y: a + COORD_W'(1),
                                         pixel_color: r_color, weight: ~w,
                                         opaque: 1'b0, last: 1'b0};
                            n_out_valid = 1'b1;
                            n_state     = ST_SECOND;
                            n_steps     = lst ? '0 : r_steps - STEPS_W'(1);
                            if (lst) begin
                                n_mode = MODE_FINAL;
                            end
                        end
                        MODE_FINAL: begin
                            n_out       = '{pixel_x: r_fin_x, pixel_y: r_fin_y,
                                            pixel_color: r_color, weight: '0,
                                            opaque: 1'b0, last: 1'b1};
                            n_out_valid = 1'b1;
                            n_mode      = MODE_IDLE;
                        end
                        default: begin
                            // drop an advance with no line in progress
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_rem     = qbit ? COORD_W'(shifted - {1'b0, r_den})
                                 : COORD_W'(shifted);
                n_estep   = {r_estep[FRAC_W-2:0], qbit};
                n_div_cnt = r_div_cnt - DCNT_W'(1);
                if (r_div_cnt == DCNT_W'(1)) begin
                    n_state = ST_READY;
                end
            end
            ST_SECOND: begin
                if (out_free) begin
                    n_out       = r_second;
                    n_out_valid = 1'b1;
                    n_state     = ST_READY;
                end
            end
            default: begin
                n_state = ST_READY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_mode      <= MODE_IDLE;
            r_out_valid <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
            r_div_cnt   <= n_div_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x  <= n_cur_x;
        r_cur_y  <= n_cur_y;
        r_fin_x  <= n_fin_x;
        r_fin_y  <= n_fin_y;
        r_left   <= n_left;
        r_steps  <= n_steps;
        r_acc    <= n_acc;
        r_estep  <= n_estep;
        r_color  <= n_color;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_out    <= n_out;
        r_second <= n_second;
    end

endmodule

/* src/antialiased_line_raster_core.sv */
// Antialiased line rasterizer, top level: front end, command queue, back end.
// A start command sorts the endpoints by row and registers the first dot; for
// lines that are neither horizontal, vertical nor diagonal the back end then
// runs its one-bit-per-cycle slope divider to completion before it takes the
// next command. An advance on a line in progress gives its single write in the
// cycle after the back end takes it, or its pair of blended writes in turn
// through the one output register, the second held until the output is free.
// Commands wait in a P_QDEPTH-entry queue during division or an output stall.
// Depends on alr_pkg, alr_front, alr_queue and alr_back.
module antialiased_line_raster_core #(
    parameter int P_QDEPTH = alr_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  alr_pkg::t_in_item  i_item,
    input  logic               i_valid,
    output logic               o_ready,
    output alr_pkg::t_out_item o_item,
    output logic               o_valid,
    input  logic               i_ready
);
    import alr_pkg::*;

    t_cmd front_cmd, queue_cmd;
    logic front_valid, front_ready, queue_valid, queue_ready;

    alr_front u_front (
        .i_item      (i_item),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready)
    );

    alr_queue #(
        .DEPTH (P_QDEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_data  (front_cmd),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .o_rd_data  (queue_cmd),
        .o_rd_valid (queue_valid),
        .i_rd_ready (queue_ready)
    );

    alr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .o_item      (o_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready)
    );

endmodule

/* verif/tb_antialiased_line_raster_core.sv */
// Self-checking testbench for antialiased_line_raster_core: directed lines, then random lines
// under several idle/stall mixes, each pixel write checked against a line-walking predictor.
// Depends on alr_pkg and antialiased_line_raster_core from src.
module tb_antialiased_line_raster_core;
    timeunit 1ns;
    timeprecision 1ps;

    import alr_pkg::*;

    localparam int ITEMS_PER_PHASE = 500;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 40;

    // Walks each line the way the block should and keeps the pixel writes still owed.
    class line_pixel_tracker;
        logic [2:0]          mode;
        logic [COORD_W-1:0]  cur_x, cur_y, end_x, end_y;
        logic                left;
        int unsigned         steps;
        logic [31:0]         accum, slope;
        logic [COLOR_W-1:0]  color;
        t_out_item           pending_pixels[$];
        int unsigned         n_errors;
        int unsigned         n_checked;

        function new();
            mode = MODE_IDLE;
            cur_x = '0; cur_y = '0; end_x = '0; end_y = '0;
            left = 1'b0; steps = 0; accum = '0; slope = '0; color = '0;
            n_errors = 0; n_checked = 0;
        endfunction

        function bit drawing();
            return mode != MODE_IDLE;
        endfunction

        function void queue_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [WEIGHT_W-1:0] w, logic opq, logic lst);
            t_out_item px;
            px.pixel_x = x;
            px.pixel_y = y;
            px.pixel_color = color;
            px.weight = w;
            px.opaque = opq;
            px.last = lst;
            pending_pixels.push_back(px);
        endfunction

        function void accept_command(t_in_item cmd);
            logic [COORD_W-1:0]  sx, sy, ex, ey, tmp, dx, dy, a, ofs;
            logic [WEIGHT_W-1:0] w;
            logic                lst;
            if (cmd.command == CMD_START) begin
                color = cmd.color_index;
                sx = cmd.start_x; sy = cmd.start_y;
                ex = cmd.end_x;   ey = cmd.end_y;
                // walk from the smaller row
                if (sy > ey) begin
                    tmp = sy; sy = ey; ey = tmp;
                    tmp = sx; sx = ex; ex = tmp;
                end
                queue_pixel(sx, sy, '0, 1'b0, 1'b0);
                left = (ex < sx);
                dx = left ? sx - ex : ex - sx;
                dy = ey - sy;
                cur_x = sx; cur_y = sy; end_x = ex; end_y = ey;
                accum = '0; slope = '0;
                if (dy == 0) begin
                    mode = MODE_RUN_H;
                    cur_x = left ? ex : sx;
                    steps = dx + 1;
                end else if (dx == 0) begin
                    mode = MODE_RUN_V;
                    steps = dy;
                end else if (dx == dy) begin
                    mode = MODE_RUN_D;
                    steps = dy;
                end else if (dy > dx) begin
                    mode = MODE_AA_Y;
                    slope = (32'(dx) << FRAC_W) / 32'(dy);
                    steps = dy - 1;
                end else begin
                    mode = MODE_AA_X;
                    slope = (32'(dy) << FRAC_W) / 32'(dx);
                    steps = dx - 1;
                end
            end else begin
                case (mode)
                    MODE_RUN_H, MODE_RUN_V, MODE_RUN_D: begin
                        lst = (steps <= 1);
                        queue_pixel(cur_x, cur_y, '0, 1'b1, lst);
                        if (mode == MODE_RUN_H) begin
                            cur_x = cur_x + 1'b1;
                        end else begin
                            cur_y = cur_y + 1'b1;
                            if (mode == MODE_RUN_D) begin
                                cur_x = left ? cur_x - 1'b1 : cur_x + 1'b1;
                            end
                        end
                        if (lst) begin
                            steps = 0;
                            mode = MODE_IDLE;
                        end else begin
                            steps--;
                        end
                    end
                    MODE_AA_Y, MODE_AA_X: begin
                        accum = accum + slope;
                        w = accum[FRAC_W-1 -: WEIGHT_W];
                        ofs = accum[FRAC_W +: COORD_W];
                        // second dot of the pair carries the complementary weight
                        if (mode == MODE_AA_Y) begin
                            cur_y = cur_y + 1'b1;
                            a = left ? cur_x - ofs : cur_x + ofs;
                            queue_pixel(a, cur_y, w, 1'b0, 1'b0);
                            queue_pixel(left ? a - 1'b1 : a + 1'b1, cur_y, ~w, 1'b0, 1'b0);
                        end else begin
                            cur_x = left ? cur_x - 1'b1 : cur_x + 1'b1;
                            a = cur_y + ofs;
                            queue_pixel(cur_x, a, w, 1'b0, 1'b0);
                            queue_pixel(cur_x, a + 1'b1, ~w, 1'b0, 1'b0);
                        end
                        if (steps <= 1) begin
                            steps = 0;
                            mode = MODE_FINAL;
                        end else begin
                            steps--;
                        end
                    end
                    MODE_FINAL: begin
                        queue_pixel(end_x, end_y, '0, 1'b0, 1'b1);
                        mode = MODE_IDLE;
                    end
                    default: ;
                endcase
            end
        endfunction

        function void check_pixel(t_out_item got);
            t_out_item want;
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel write x=%0d y=%0d", got.pixel_x, got.pixel_y);
                n_errors++;
                return;
            end
            want = pending_pixels.pop_front();
            n_checked++;
            if (got.pixel_x !== want.pixel_x) begin
                $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
                n_errors++;
            end
            if (got.pixel_y !== want.pixel_y) begin
                $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
                n_errors++;
            end
            if (got.pixel_color !== want.pixel_color) begin
                $error("pixel_color: expected %0d, got %0d", want.pixel_color, got.pixel_color);
                n_errors++;
            end
            if (got.weight !== want.weight) begin
                $error("weight: expected %0d, got %0d", want.weight, got.weight);
                n_errors++;
            end
            if (got.opaque !== want.opaque) begin
                $error("opaque: expected %0d, got %0d", want.opaque, got.opaque);
                n_errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                n_errors++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    t_in_item  i_item = '0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_out_item o_item;
    logic      o_valid;
    logic      i_ready = 1'b0;

    line_pixel_tracker tracker = new();

    int send_idle_pct = 0;
    int stall_pct = 0;
    int n_items = 0;
    int n_ignored = 0;
    int n_lines = 0;

    antialiased_line_raster_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_item  (o_item),
        .o_valid (o_valid),
        .i_ready (i_ready)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check outputs before noting the input: a write leaving now belongs to older items.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) tracker.check_pixel(o_item);
            if (i_valid && o_ready) tracker.accept_command(i_item);
        end
    end

    initial begin
        #10ms;
        $display("[antialiased_line_raster_core] ERROR");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_command(input t_in_item cmd);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_item <= cmd;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic t_in_item random_payload();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_item)-1:0];
    endfunction

    task automatic advance();
        t_in_item cmd;
        cmd = random_payload();
        cmd.command = CMD_ADVANCE;
        if (tracker.drawing()) n_items++;
        else n_ignored++;
        send_command(cmd);
    endtask

    task automatic draw_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                             input logic [COLOR_W-1:0] color, input int max_adv);
        t_in_item cmd;
        int       n;
        cmd = random_payload();
        cmd.command = CMD_START;
        cmd.start_x = sx;
        cmd.start_y = sy;
        cmd.end_x = ex;
        cmd.end_y = ey;
        cmd.color_index = color;
        n_items++;
        n_lines++;
        send_command(cmd);
        n = 0;
        while (n < max_adv && tracker.drawing()) begin
            advance();
            n++;
        end
    endtask

    // Move a coordinate by d in a random direction that stays on the grid.
    function automatic logic [COORD_W-1:0] offset_coord(logic [COORD_W-1:0] c, int d);
        int v;
        if ($urandom_range(1) == 1 && int'(c) >= d) v = int'(c) - d;
        else if (int'(c) + d <= (1 << COORD_W) - 1) v = int'(c) + d;
        else v = int'(c) - d;
        return v[COORD_W-1:0];
    endfunction

    task automatic random_line();
        int                 size_pick, kind, d1, d2, span, max_adv;
        logic [COORD_W-1:0] sx, sy, ex, ey;
        size_pick = $urandom_range(99);
        kind = $urandom_range(4);
        sx = COORD_W'($urandom_range((1 << COORD_W) - 1));
        sy = COORD_W'($urandom_range((1 << COORD_W) - 1));
        if (size_pick < 6) begin
            // long lines: exercise the slope division, then cut short
            ex = COORD_W'($urandom_range((1 << COORD_W) - 1));
            ey = COORD_W'($urandom_range((1 << COORD_W) - 1));
            if (kind == 0) ey = sy;
            if (kind == 1) ex = sx;
            max_adv = $urandom_range(40);
        end else begin
            span = (size_pick < 16) ? 300 : 15;
            d1 = $urandom_range(span);
            d2 = $urandom_range(span);
            case (kind)
                0: d2 = 0;
                1: d1 = 0;
                2: d2 = d1;
                default: ;
            endcase
            ex = offset_coord(sx, d1);
            ey = offset_coord(sy, d2);
            max_adv = ($urandom_range(99) < 12) ? $urandom_range(6) : 32'h7fff_ffff;
        end
        draw_line(sx, sy, ex, ey, COLOR_W'($urandom_range(255)), max_adv);
    endtask

    int send_pcts[4]  = '{0, 50, 0, 18};
    int stall_pcts[4] = '{0, 0, 50, 18};

    initial begin
        int phase_end;
        int drain_cycles;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        advance();                                                     // idle: no write
        draw_line(12'd4095, 12'd7, 12'd4093, 12'd7, 8'd255, 100);      // horizontal, leftward
        draw_line(12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 100);              // single point
        draw_line(12'd5, 12'd4095, 12'd5, 12'd4093, 8'h5a, 100);       // vertical, swapped
        draw_line(12'd2, 12'd0, 12'd0, 12'd2, 8'ha5, 100);             // diagonal, leftward
        draw_line(12'd10, 12'd0, 12'd8, 12'd3, 8'd17, 100);            // steep, leftward
        draw_line(12'd0, 12'd4093, 12'd3, 12'd4095, 8'd200, 100);      // shallow, rightward
        draw_line(12'd0, 12'd0, 12'd4095, 12'd4095, 8'd1, 1);          // abandoned by next start
        draw_line(12'd4095, 12'd0, 12'd0, 12'd4094, 8'd254, 2);        // widest slope

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pcts[p];
            stall_pct = stall_pcts[p];
            phase_end = n_items + ITEMS_PER_PHASE;
            while (n_items < phase_end) begin
                if ($urandom_range(99) < 4) advance();
                else random_line();
            end
        end
        i_valid <= 1'b0;

        drain_cycles = 0;
        while (tracker.pending_pixels.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        if (drain_cycles >= DRAIN_LIMIT) begin
            $display("[antialiased_line_raster_core] ERROR");
        end else begin
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            $display("Drove %0d commands (%0d lines, %0d advances while idle)",
                     n_items, n_lines, n_ignored);
            $display("Checked %0d pixel writes across four idle/stall mixes",
                     tracker.n_checked);
            if (tracker.n_errors == 0) begin
                $display("[antialiased_line_raster_core] OK");
            end else begin
                $display("[antialiased_line_raster_core] ERROR");
            end
        end
        $finish;
    end
endmodule
